### hdl/hmpe_pkg.sv
// Shared types and constants for the haptic motor pulse envelope.
`default_nettype none
package hmpe_pkg;

    localparam int QUEUE_DEPTH = 3;

    // Request op codes (carried on tuser)
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_REQUEST   = 3'd1;
    localparam logic [2:0] OP_DECAY     = 3'd2;
    localparam logic [2:0] OP_SLIP      = 3'd3;
    localparam logic [2:0] OP_SUBMERGED = 3'd4;
    localparam logic [2:0] OP_CANCEL    = 3'd5;

    // Motor command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Event kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_STRONG = 2'd1;
    localparam logic [1:0] KIND_WEAK   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STRONG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_FAULT_LIMIT      = 2'd1;
    localparam logic [1:0] CFG_RETRY_PERIOD     = 2'd2;

    localparam logic [7:0] STRONG_THRESHOLD_RST = 8'd70;
    localparam logic [5:0] FAULT_LIMIT_RST      = 6'd30;
    localparam logic [7:0] RETRY_PERIOD_RST     = 8'd60;

    localparam logic [2:0]  KICK_TICKS       = 3'd4;
    localparam logic [2:0]  SLIP_FULL        = 3'd7;
    localparam logic [2:0]  SLIP_MIN         = 3'd4;
    localparam logic [2:0]  SLIP_HOLD        = 3'd5;
    localparam logic [2:0]  SLIP_PULSE       = 3'd2;
    localparam logic [2:0]  SUBMERGED_PERIOD = 3'd4;
    localparam logic [5:0]  FAULT_MAX        = 6'd63;
    localparam logic [16:0] ACCUM_SPEND      = 17'h00100;
    localparam logic [16:0] ACCUM_BIAS       = 17'd4;
    localparam logic [15:0] IDLE_LIMIT       = 16'd4;

    // Tick counter remainder: radix-2 digits, several per cycle
    localparam int TICK_W        = 32;
    localparam int DIV_BITS      = 4;
    localparam int DIV_STEPS     = TICK_W / DIV_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [14:0] ticks;
        logic [7:0]  level;
        logic [7:0]  decay;
    } slot_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic div_step;
        logic mul_sq;
        logic mul_cube;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

endpackage
`default_nettype wire

### hdl/hmpe_ctrl.sv
// Sequencer for one request: a tick runs load, remainder digits, cube multiply, commit; other ops commit directly.
`default_nettype none
module hmpe_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic [2:0]          s_tuser,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire hmpe_pkg::dp_status_t status,
    output hmpe_pkg::dp_cmd_t        cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MUL_SQ,
        S_MUL_CUBE,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   valid_reg;
    logic   accept;
    logic   out_free;

    assign s_tready = ready_reg;
    assign m_tvalid = valid_reg;
    assign accept   = s_tvalid && ready_reg;
    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = accept;
        cmd.load     = (state_reg == S_LOAD);
        cmd.div_step = (state_reg == S_DIV);
        cmd.mul_sq   = (state_reg == S_MUL_SQ);
        cmd.mul_cube = (state_reg == S_MUL_CUBE);
        cmd.finish   = (state_reg == S_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ready_reg <= 1'b0;
                        state_reg <= (s_tuser == hmpe_pkg::OP_TICK) ? S_LOAD : S_FINISH;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (status.div_last)
                    begin
                        state_reg <= S_MUL_SQ;
                    end
                end
                S_MUL_SQ:
                begin
                    state_reg <= S_MUL_CUBE;
                end
                S_MUL_CUBE:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // hold until the output register can take the result
                    if (out_free)
                    begin
                        ready_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/hmpe_dp.sv
// Datapath: queue, envelope state, fault tracking, remainder and cube units.
`default_nettype none
module hmpe_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hmpe_pkg::dp_cmd_t   cmd,
    output hmpe_pkg::dp_status_t     status,
    input  wire logic [2:0]          in_op,
    input  wire logic [14:0]         in_duration,
    input  wire logic [7:0]          in_intensity,
    input  wire logic [7:0]          in_decay_step,
    input  wire logic [2:0]          in_vibrate_period,
    input  wire logic                in_resetting,
    input  wire logic                in_motor_fault,
    input  wire logic                in_probe_ok,
    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [7:0]          cfg_data,
    output logic [7:0]               out_data
);

    localparam int QD = hmpe_pkg::QUEUE_DEPTH;
    localparam int TW = hmpe_pkg::TICK_W;
    localparam int DB = hmpe_pkg::DIV_BITS;
    localparam int CW = hmpe_pkg::DIV_CNT_W;

    // configuration
    logic [7:0] strong_threshold_reg;
    logic [5:0] fault_limit_reg;
    logic [7:0] retry_period_reg;

    // captured request
    logic [2:0]  op_reg;
    logic [14:0] duration_reg;
    logic [7:0]  intensity_reg;
    logic [7:0]  decay_step_reg;
    logic [2:0]  vibrate_period_reg;
    logic        resetting_reg;
    logic        motor_fault_reg;
    logic        probe_ok_reg;

    // envelope state
    hmpe_pkg::slot_t queue_reg [QD];
    hmpe_pkg::slot_t queue_next [QD];
    logic [2:0]  kick_left_reg, kick_left_next;
    logic [1:0]  event_kind_reg, event_kind_next;
    logic [14:0] ticks_left_reg, ticks_left_next;
    logic [7:0]  cur_level_reg, cur_level_next;
    logic [7:0]  cur_decay_reg, cur_decay_next;
    logic [16:0] pulse_accum_reg, pulse_accum_next;
    logic [2:0]  slip_left_reg, slip_left_next;
    logic [2:0]  pulse_period_reg, pulse_period_next;
    logic        enabled_reg, enabled_next;
    logic [5:0]  fault_count_reg, fault_count_next;
    logic [TW-1:0] tick_count_reg, tick_count_next;

    // remainder unit
    logic [TW-1:0] div_sh_reg;
    logic [CW-1:0] div_cnt_reg;
    logic [7:0]    rem_a_reg, rem_a_step;
    logic [2:0]    rem_b_reg, rem_b_step;
    logic [7:0]    div_pa;
    logic [2:0]    div_pb;
    logic [8:0]    div_ta;
    logic [3:0]    div_tb;

    // cube unit
    logic [7:0]  level_dec;
    logic [15:0] sq_reg;
    logic [23:0] cube_reg;
    logic [16:0] accum_add;

    // commit
    logic [1:0]  req_cmd;
    logic [1:0]  motor_cmd;
    logic [5:0]  fault_issued;
    logic [15:0] busy_sum;
    logic        any_valid;
    logic        all_idle;
    logic [7:0]  out_data_reg;

    assign out_data        = out_data_reg;
    assign status.div_last = (div_cnt_reg == hmpe_pkg::DIV_LAST);

    assign level_dec = (cur_level_reg > cur_decay_reg) ? cur_level_reg - cur_decay_reg : 8'd0;
    assign accum_add = pulse_accum_reg + {2'b00, cube_reg[23:9]} + hmpe_pkg::ACCUM_BIAS;

    assign div_pa = (retry_period_reg == 8'd0) ? 8'd1 : retry_period_reg;
    assign div_pb = (pulse_period_reg == 3'd0) ? 3'd1 : pulse_period_reg;

    // restoring remainder, several dividend bits per cycle, MSB first
    always_comb
    begin
        rem_a_step = rem_a_reg;
        rem_b_step = rem_b_reg;
        div_ta     = '0;
        div_tb     = '0;
        for (int k = 0; k < DB; k++)
        begin
            div_ta = {rem_a_step, div_sh_reg[TW-1-k]};
            if (div_ta >= {1'b0, div_pa})
            begin
                div_ta = div_ta - {1'b0, div_pa};
            end
            rem_a_step = div_ta[7:0];
            div_tb = {rem_b_step, div_sh_reg[TW-1-k]};
            if (div_tb >= {1'b0, div_pb})
            begin
                div_tb = div_tb - {1'b0, div_pb};
            end
            rem_b_step = div_tb[2:0];
        end
    end

    always_comb
    begin
        queue_next        = queue_reg;
        kick_left_next    = kick_left_reg;
        event_kind_next   = event_kind_reg;
        ticks_left_next   = ticks_left_reg;
        cur_level_next    = cur_level_reg;
        cur_decay_next    = cur_decay_reg;
        pulse_accum_next  = pulse_accum_reg;
        slip_left_next    = slip_left_reg;
        pulse_period_next = pulse_period_reg;
        enabled_next      = enabled_reg;
        fault_count_next  = fault_count_reg;
        tick_count_next   = tick_count_reg;
        req_cmd           = hmpe_pkg::CMD_STOP;
        motor_cmd         = hmpe_pkg::CMD_NONE;
        fault_issued      = fault_count_reg;

        if (cmd.load)
        begin
            // take the head slot as the current event if it holds one, then advance the queue
            if (queue_reg[0].kind != hmpe_pkg::KIND_NONE)
            begin
                pulse_accum_next = '0;
                kick_left_next   = hmpe_pkg::KICK_TICKS;
                event_kind_next  = queue_reg[0].kind;
                ticks_left_next  = queue_reg[0].ticks;
                cur_level_next   = queue_reg[0].level;
                cur_decay_next   = queue_reg[0].decay;
            end
            for (int i = 0; i < QD - 1; i++)
            begin
                queue_next[i] = queue_reg[i+1];
            end
            queue_next[QD-1].kind = hmpe_pkg::KIND_NONE;
        end
        else if (cmd.finish)
        begin
            unique case (op_reg)
                hmpe_pkg::OP_TICK:
                begin
                    if (!resetting_reg)
                    begin
                        if (kick_left_reg != 3'd0)
                        begin
                            kick_left_next = kick_left_reg - 3'd1;
                            req_cmd = hmpe_pkg::CMD_START;
                        end
                        else if (ticks_left_reg != 15'd0)
                        begin
                            ticks_left_next = ticks_left_reg - 15'd1;
                            cur_level_next  = level_dec;
                            if (event_kind_reg == hmpe_pkg::KIND_STRONG)
                            begin
                                req_cmd = hmpe_pkg::CMD_START;
                            end
                            else if (pulse_accum_reg >= hmpe_pkg::ACCUM_SPEND)
                            begin
                                pulse_accum_next = pulse_accum_reg - hmpe_pkg::ACCUM_SPEND;
                                req_cmd = hmpe_pkg::CMD_START;
                            end
                            else
                            begin
                                pulse_accum_next = accum_add;
                            end
                        end
                        else if (slip_left_reg >= hmpe_pkg::SLIP_HOLD)
                        begin
                            req_cmd = hmpe_pkg::CMD_START;
                        end
                        else if (slip_left_reg >= hmpe_pkg::SLIP_PULSE &&
                                 pulse_period_reg != 3'd0 && rem_b_reg == 3'd0)
                        begin
                            req_cmd = hmpe_pkg::CMD_START;
                        end
                        if (slip_left_reg != 3'd0)
                        begin
                            slip_left_next = slip_left_reg - 3'd1;
                        end
                    end
                    if (enabled_reg)
                    begin
                        motor_cmd = req_cmd;
                        if (!motor_fault_reg)
                        begin
                            fault_issued = '0;
                        end
                        else if (fault_count_reg != hmpe_pkg::FAULT_MAX)
                        begin
                            fault_issued = fault_count_reg + 6'd1;
                        end
                        fault_count_next = fault_issued;
                        if (fault_issued >= fault_limit_reg)
                        begin
                            enabled_next = 1'b0;
                        end
                    end
                    else if (rem_a_reg == 8'd0)
                    begin
                        // re-probe a disabled motor
                        enabled_next     = probe_ok_reg;
                        fault_count_next = '0;
                    end
                    tick_count_next = tick_count_reg + TW'(1);
                end
                hmpe_pkg::OP_REQUEST:
                begin
                    queue_next[QD-1].kind  = (intensity_reg > strong_threshold_reg) ?
                                             hmpe_pkg::KIND_STRONG : hmpe_pkg::KIND_WEAK;
                    queue_next[QD-1].level = intensity_reg;
                    queue_next[QD-1].ticks = duration_reg;
                    queue_next[QD-1].decay = 8'd0;
                end
                hmpe_pkg::OP_DECAY:
                begin
                    queue_next[QD-1].decay = decay_step_reg;
                end
                hmpe_pkg::OP_SLIP:
                begin
                    if (slip_left_reg == 3'd0)
                    begin
                        slip_left_next = hmpe_pkg::SLIP_FULL;
                    end
                    else if (slip_left_reg < hmpe_pkg::SLIP_MIN)
                    begin
                        slip_left_next = hmpe_pkg::SLIP_MIN;
                    end
                    if (vibrate_period_reg != 3'd0)
                    begin
                        pulse_period_next = vibrate_period_reg;
                    end
                end
                hmpe_pkg::OP_SUBMERGED:
                begin
                    slip_left_next    = hmpe_pkg::SLIP_MIN;
                    pulse_period_next = hmpe_pkg::SUBMERGED_PERIOD;
                end
                hmpe_pkg::OP_CANCEL:
                begin
                    enabled_next = probe_ok_reg;
                    if (probe_ok_reg)
                    begin
                        motor_cmd = hmpe_pkg::CMD_STOP;
                    end
                    for (int i = 0; i < QD; i++)
                    begin
                        queue_next[i].kind = hmpe_pkg::KIND_NONE;
                    end
                    ticks_left_next = '0;
                    slip_left_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        any_valid = 1'b0;
        for (int i = 0; i < QD; i++)
        begin
            if (queue_next[i].kind != hmpe_pkg::KIND_NONE)
            begin
                any_valid = 1'b1;
            end
        end
        busy_sum = {13'd0, kick_left_next} + {1'b0, ticks_left_next};
        all_idle = (busy_sum < hmpe_pkg::IDLE_LIMIT) && !any_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strong_threshold_reg <= hmpe_pkg::STRONG_THRESHOLD_RST;
            fault_limit_reg      <= hmpe_pkg::FAULT_LIMIT_RST;
            retry_period_reg     <= hmpe_pkg::RETRY_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hmpe_pkg::CFG_STRONG_THRESHOLD: strong_threshold_reg <= cfg_data;
                hmpe_pkg::CFG_FAULT_LIMIT:      fault_limit_reg      <= cfg_data[5:0];
                hmpe_pkg::CFG_RETRY_PERIOD:     retry_period_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QD; i++)
            begin
                queue_reg[i] <= '0;
            end
            kick_left_reg    <= '0;
            event_kind_reg   <= '0;
            ticks_left_reg   <= '0;
            cur_level_reg    <= '0;
            cur_decay_reg    <= '0;
            pulse_accum_reg  <= '0;
            slip_left_reg    <= '0;
            pulse_period_reg <= '0;
            enabled_reg      <= 1'b0;
            fault_count_reg  <= '0;
            tick_count_reg   <= '0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            queue_reg        <= queue_next;
            kick_left_reg    <= kick_left_next;
            event_kind_reg   <= event_kind_next;
            ticks_left_reg   <= ticks_left_next;
            cur_level_reg    <= cur_level_next;
            cur_decay_reg    <= cur_decay_next;
            pulse_accum_reg  <= pulse_accum_next;
            slip_left_reg    <= slip_left_next;
            pulse_period_reg <= pulse_period_next;
            enabled_reg      <= enabled_next;
            fault_count_reg  <= fault_count_next;
            tick_count_reg   <= tick_count_next;
            if (cmd.load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg             <= in_op;
            duration_reg       <= in_duration;
            intensity_reg      <= in_intensity;
            decay_step_reg     <= in_decay_step;
            vibrate_period_reg <= in_vibrate_period;
            resetting_reg      <= in_resetting;
            motor_fault_reg    <= in_motor_fault;
            probe_ok_reg       <= in_probe_ok;
        end
        if (cmd.load)
        begin
            div_sh_reg <= tick_count_reg;
            rem_a_reg  <= '0;
            rem_b_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            div_sh_reg <= div_sh_reg << DB;
            rem_a_reg  <= rem_a_step;
            rem_b_reg  <= rem_b_step;
        end
        if (cmd.mul_sq)
        begin
            sq_reg <= level_dec * level_dec;
        end
        if (cmd.mul_cube)
        begin
            cube_reg <= sq_reg * level_dec;
        end
        if (cmd.finish)
        begin
            out_data_reg <= {4'd0, all_idle, enabled_next, motor_cmd};
        end
    end

endmodule
`default_nettype wire

### hdl/haptic_motor_pulse_envelope.sv
// Top level of the haptic motor pulse envelope: ports, field unpacking, checks.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------
//  request   | s_tvalid / s_tready   | s_tuser op, s_tdata request fields
//  result    | m_tvalid / m_tready   | m_tdata motor_cmd, enabled, idle
//  config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A tick request runs load, the 4-bit-per-cycle remainder unit on the 32-bit
// tick counter, two multiply stages for the cube, commit. Every other op goes
// straight from accept to commit. Ready returns with the result, so the next
// request waits for the commit, which holds while an earlier result still
// waits and m_tready stays low. Reset clears control, config and envelope state,
// not the captured request or result; config writes are accepted in every cycle.
`default_nettype none
module haptic_motor_pulse_envelope (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [14:0] duration, [22:15] intensity, [30:23] decay_step,
    // [33:31] vibrate_period, [34] resetting, [35] motor_fault, [36] probe_ok
    input  wire logic [39:0] s_tdata,
    // [2:0] op
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] motor_cmd, [2] motor_enabled, [3] all_idle
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    hmpe_pkg::dp_cmd_t    dp_cmd;
    hmpe_pkg::dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    hmpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    hmpe_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (dp_cmd),
        .status            (dp_status),
        .in_op             (s_tuser),
        .in_duration       (s_tdata[14:0]),
        .in_intensity      (s_tdata[22:15]),
        .in_decay_step     (s_tdata[30:23]),
        .in_vibrate_period (s_tdata[33:31]),
        .in_resetting      (s_tdata[34]),
        .in_motor_fault    (s_tdata[35]),
        .in_probe_ok       (s_tdata[36]),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_data          (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // one request at a time: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // a commit always presents its result
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.finish |=> m_tvalid)
        else $error("commit without result valid");

    // a result appears only from a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(dp_cmd.finish))
        else $error("result valid without commit");
`endif

endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the haptic motor pulse envelope.
`timescale 1ns / 1ps

import hmpe_pkg::*;

class envelope_scoreboard;
    slot_t       slots[QUEUE_DEPTH];
    logic [7:0]  strong_thr;
    logic [5:0]  fault_lim;
    logic [7:0]  retry_per;
    logic [2:0]  kick_left;
    logic [1:0]  ev_kind;
    logic [14:0] ticks_left;
    logic [7:0]  level;
    logic [7:0]  decay;
    logic [16:0] accum;
    logic [2:0]  slip_left;
    logic [2:0]  pulse_per;
    logic        enabled;
    logic [5:0]  faults;
    logic [31:0] tick_cnt;
    // {all_idle, motor_enabled, motor_cmd} per accepted request
    logic [3:0]  expected_results[$];
    int          errors;

    function new();
        strong_thr = STRONG_THRESHOLD_RST;
        fault_lim  = FAULT_LIMIT_RST;
        retry_per  = RETRY_PERIOD_RST;
        foreach (slots[i])
            slots[i] = '0;
        kick_left  = '0;
        ev_kind    = KIND_NONE;
        ticks_left = '0;
        level      = '0;
        decay      = '0;
        accum      = '0;
        slip_left  = '0;
        pulse_per  = '0;
        enabled    = 1'b0;
        faults     = '0;
        tick_cnt   = '0;
        errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
        case (idx)
            CFG_STRONG_THRESHOLD: strong_thr = val;
            CFG_FAULT_LIMIT:      fault_lim  = val[5:0];
            CFG_RETRY_PERIOD:     retry_per  = val;
            default: ;
        endcase
    endfunction

    // Issue a command to the motor and track consecutive failures.
    function logic [1:0] drive_motor(logic [1:0] cmd, logic fault);
        if (!enabled)
            return CMD_NONE;
        if (fault) begin
            if (faults < FAULT_MAX)
                faults++;
        end
        else
            faults = '0;
        return cmd;
    endfunction

    function logic [1:0] run_envelope(logic rst_pending, logic fault);
        logic [1:0]  cmd;
        logic [31:0] cube;
        if (rst_pending)
            return drive_motor(CMD_STOP, fault);
        if (kick_left != 0) begin
            kick_left--;
            cmd = drive_motor(CMD_START, fault);
        end
        else if (ticks_left != 0) begin
            ticks_left--;
            level = (level > decay) ? level - decay : 8'd0;
            if (ev_kind == KIND_STRONG)
                cmd = drive_motor(CMD_START, fault);
            else if (accum >= ACCUM_SPEND) begin
                accum = accum - ACCUM_SPEND;
                cmd = drive_motor(CMD_START, fault);
            end
            else begin
                cube  = 32'(level) * 32'(level) * 32'(level);
                accum = accum + 17'(cube >> 9) + ACCUM_BIAS;
                cmd = drive_motor(CMD_STOP, fault);
            end
        end
        else begin
            if (slip_left >= SLIP_HOLD)
                cmd = drive_motor(CMD_START, fault);
            else if (slip_left >= SLIP_PULSE && pulse_per != 0 &&
                     tick_cnt % 32'(pulse_per) == 0)
                cmd = drive_motor(CMD_START, fault);
            else
                cmd = drive_motor(CMD_STOP, fault);
        end
        if (slip_left != 0)
            slip_left--;
        return cmd;
    endfunction

    function void note_request(logic [2:0] op, logic [39:0] data);
        logic [14:0] dur;
        logic [7:0]  inten;
        logic [7:0]  dstep;
        logic [2:0]  vib;
        logic        rst_pending;
        logic        fault;
        logic        probe;
        logic [1:0]  cmd;
        logic [31:0] per;
        logic        idle;
        dur         = data[14:0];
        inten       = data[22:15];
        dstep       = data[30:23];
        vib         = data[33:31];
        rst_pending = data[34];
        fault       = data[35];
        probe       = data[36];
        cmd         = CMD_NONE;
        case (op)
            OP_TICK: begin
                per = (retry_per != 0) ? 32'(retry_per) : 32'd1;
                if (slots[0].kind != KIND_NONE) begin
                    accum      = '0;
                    kick_left  = KICK_TICKS;
                    ev_kind    = slots[0].kind;
                    ticks_left = slots[0].ticks;
                    level      = slots[0].level;
                    decay      = slots[0].decay;
                end
                // shift; the tail keeps its payload, only its kind clears
                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    slots[i] = slots[i + 1];
                slots[QUEUE_DEPTH - 1].kind = KIND_NONE;
                cmd = run_envelope(rst_pending, fault);
                if (enabled) begin
                    if (faults >= fault_lim)
                        enabled = 1'b0;
                end
                else if (tick_cnt % per == 0) begin
                    enabled = probe;
                    faults  = '0;
                end
                tick_cnt++;
            end
            OP_REQUEST: begin
                slots[QUEUE_DEPTH - 1].kind  = (inten > strong_thr) ? KIND_STRONG : KIND_WEAK;
                slots[QUEUE_DEPTH - 1].level = inten;
                slots[QUEUE_DEPTH - 1].ticks = dur;
                slots[QUEUE_DEPTH - 1].decay = '0;
            end
            OP_DECAY:
                slots[QUEUE_DEPTH - 1].decay = dstep;
            OP_SLIP: begin
                if (slip_left == 0)
                    slip_left = SLIP_FULL;
                if (slip_left < SLIP_MIN)
                    slip_left = SLIP_MIN;
                if (vib != 0)
                    pulse_per = vib;
            end
            OP_SUBMERGED: begin
                slip_left = SLIP_MIN;
                pulse_per = SUBMERGED_PERIOD;
            end
            OP_CANCEL: begin
                enabled = probe;
                if (enabled)
                    cmd = CMD_STOP;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    slots[i].kind = KIND_NONE;
                ticks_left = '0;
                slip_left  = '0;
            end
            default: ;
        endcase
        idle = (16'(kick_left) + 16'(ticks_left)) < IDLE_LIMIT;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (slots[i].kind != KIND_NONE)
                idle = 1'b0;
        expected_results.push_back({idle, enabled, cmd});
    endfunction

    function void check_result(logic [7:0] data);
        logic [3:0] want;
        if (expected_results.size() == 0) begin
            $error("result with nothing pending: motor_cmd %0d, motor_enabled %0d, all_idle %0d",
                   data[1:0], data[2], data[3]);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (data[1:0] != want[1:0]) begin
            $error("motor_cmd: expected %0d, got %0d", want[1:0], data[1:0]);
            errors++;
        end
        if (data[2] != want[2]) begin
            $error("motor_enabled: expected %0d, got %0d", want[2], data[2]);
            errors++;
        end
        if (data[3] != want[3]) begin
            $error("all_idle: expected %0d, got %0d", want[3], data[3]);
            errors++;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module tb_top;

    localparam int LIMIT       = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 155;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // [14:0] duration, [22:15] intensity, [30:23] decay_step,
    // [33:31] vibrate_period, [34] resetting, [35] motor_fault, [36] probe_ok
    logic [39:0] s_tdata;
    // [2:0] op
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // [1:0] motor_cmd, [2] motor_enabled, [3] all_idle
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    envelope_scoreboard sb = new();

    int cycles       = 0;
    int items_sent   = 0;
    int force_quick  = 0;
    int fault_pct    = 0;
    int probe_pct    = 75;
    int reset_pct    = 5;
    bit sender_quick = 1'b0;
    bit long_hold    = 1'b0;

    haptic_motor_pulse_envelope u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_TICK;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STRONG_THRESHOLD;
        cfg_data  = '0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("haptic_motor_pulse_envelope: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    function automatic logic [39:0] pack_fields(input logic [14:0] dur, input logic [7:0] inten,
                                                input logic [7:0] dstep, input logic [2:0] vib,
                                                input logic rst_pending, input logic fault,
                                                input logic probe);
        return {3'b000, probe, fault, rst_pending, vib, dstep, inten, dur};
    endfunction

    function automatic logic [39:0] noise_fields();
        return pack_fields(15'($urandom), 8'($urandom), 8'($urandom), 3'($urandom),
                           1'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [39:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        sb.note_request(op, data);
        if (op <= OP_CANCEL)
            items_sent++;
        gap = (sender_quick || force_quick > 0) ? 0 : $urandom_range(0, 9);
        if (force_quick > 0)
            force_quick--;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_tick();
        logic rst_pending;
        logic fault;
        logic probe;
        rst_pending = ($urandom_range(0, 99) < reset_pct);
        fault       = ($urandom_range(0, 99) < fault_pct);
        probe       = ($urandom_range(0, 99) < probe_pct);
        send_request(OP_TICK, pack_fields(15'($urandom), 8'($urandom), 8'($urandom),
                                          3'($urandom), rst_pending, fault, probe));
    endtask

    // Hold off the sender until every pending request has produced its result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic load_settings(input logic [7:0] thr, input logic [7:0] lim,
                                 input logic [7:0] per);
        cfg_write(CFG_STRONG_THRESHOLD, thr);
        cfg_write(CFG_FAULT_LIMIT, lim);
        cfg_write(CFG_RETRY_PERIOD, per);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result consumer: random stalls, quiet stretches, and one long hold on request.
    initial
    begin
        int stall;
        int run_left;
        bit quick;
        run_left = 0;
        quick    = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (run_left == 0) begin
                quick    = ($urandom_range(0, 3) == 0);
                run_left = $urandom_range(20, 60);
            end
            run_left--;
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                stall = quick ? 0 : $urandom_range(0, 9);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        int          target;
        int          mid;
        int          kind;
        int          r;
        bit          mid_done;
        logic [14:0] dur;
        logic [7:0]  dstep;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at reset settings: first probe, extremes, every op.
        send_request(OP_TICK, pack_fields('0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
        send_request(OP_REQUEST, pack_fields(15'h7FFF, 8'd255, '0, '0, 1'b0, 1'b0, 1'b0));
        send_request(OP_DECAY, pack_fields('0, '0, 8'd255, '0, 1'b0, 1'b0, 1'b0));
        send_request(OP_TICK, pack_fields('0, '0, '0, '0, 1'b1, 1'b0, 1'b1));
        send_request(OP_REQUEST, pack_fields(15'd5, 8'd0, '0, '0, 1'b0, 1'b0, 1'b0));
        send_request(OP_DECAY, pack_fields('0, '0, 8'd1, '0, 1'b0, 1'b0, 1'b0));
        send_request(OP_TICK, pack_fields('0, '0, '0, '0, 1'b0, 1'b1, 1'b1));
        repeat (4)
            send_request(OP_TICK, pack_fields('0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
        send_request(OP_CANCEL, pack_fields('0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
        send_request(OP_REQUEST, pack_fields(15'd20, 8'd71, '0, '0, 1'b0, 1'b0, 1'b0));
        send_request(OP_REQUEST, pack_fields(15'd20, 8'd70, '0, '0, 1'b0, 1'b0, 1'b0));
        send_request(OP_DECAY, pack_fields('0, '0, 8'd3, '0, 1'b0, 1'b0, 1'b0));
        send_request(OP_SLIP, pack_fields('0, '0, '0, 3'd0, 1'b0, 1'b0, 1'b0));
        send_request(OP_SLIP, pack_fields('0, '0, '0, 3'd7, 1'b0, 1'b0, 1'b0));
        send_request(OP_SUBMERGED, pack_fields('0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        repeat (3)
            send_request(OP_TICK, pack_fields('0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
        send_request(3'd6, noise_fields());
        send_request(3'd7, noise_fields());
        send_request(OP_CANCEL, pack_fields('0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        send_request(OP_TICK, pack_fields('0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
        drain_results();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: load_settings(8'd0, 8'd1, 8'd1);
                1: load_settings(8'd255, 8'd63, 8'd255);
                2: load_settings(8'd128, 8'd0, 8'd0);
                3: load_settings(8'($urandom), 8'($urandom_range(1, 8)),
                                 8'($urandom_range(1, 12)));
                4: load_settings(STRONG_THRESHOLD_RST, 8'(FAULT_LIMIT_RST), RETRY_PERIOD_RST);
                default: load_settings(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            target   = items_sent + PHASE_ITEMS;
            mid      = items_sent + PHASE_ITEMS / 2;
            mid_done = 1'b0;
            while (items_sent < target) begin
                if (!mid_done && items_sent >= mid) begin
                    mid_done = 1'b1;
                    if (p == 1 || p == 3) begin
                        // stall the output while requests keep coming
                        long_hold   = 1'b1;
                        force_quick = 30;
                    end
                    else if (p == 2)
                        drain_results();
                end
                r = $urandom_range(0, 9);
                fault_pct    = (r < 6) ? 0 : (r < 8) ? 15 : 90;
                sender_quick = ($urandom_range(0, 4) == 0);
                kind = $urandom_range(0, 99);
                if (kind < 55) begin
                    dur = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 12));
                    send_request(OP_REQUEST, pack_fields(dur, 8'($urandom), 8'($urandom),
                                                         3'($urandom), 1'($urandom),
                                                         1'($urandom), 1'($urandom)));
                    if ($urandom_range(0, 1) == 1) begin
                        dstep = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 8));
                        send_request(OP_DECAY, pack_fields(15'($urandom), 8'($urandom), dstep,
                                                           3'($urandom), 1'($urandom),
                                                           1'($urandom), 1'($urandom)));
                    end
                    repeat ($urandom_range(1, 8))
                        send_tick();
                end
                else if (kind < 70) begin
                    send_request(($urandom_range(0, 2) != 0) ? OP_SLIP : OP_SUBMERGED,
                                 noise_fields());
                    repeat ($urandom_range(1, 7))
                        send_tick();
                end
                else if (kind < 78) begin
                    repeat ($urandom_range(1, 10))
                        send_tick();
                end
                else if (kind < 80) begin
                    // long run of failed commands to reach the disable point
                    fault_pct = 100;
                    repeat ($urandom_range(5, 70))
                        send_tick();
                end
                else if (kind < 85)
                    send_request(OP_CANCEL, noise_fields());
                else
                    send_request(3'($urandom), noise_fields());
            end
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("haptic_motor_pulse_envelope: match");
        else
            $display("haptic_motor_pulse_envelope: mismatch");
        $finish;
    end

endmodule

### sim.f
hdl/hmpe_pkg.sv
hdl/hmpe_ctrl.sv
hdl/hmpe_dp.sv
hdl/haptic_motor_pulse_envelope.sv
test/tb_top.sv
